FILE: src/ipu_pkg.sv
// Shared types and constants for the integer pixel upscaler.
package ipu_pkg;

	// Field widths fixed by the interface.
	localparam int PIX_W      = 24;
	localparam int CHAN_W     = 8;
	localparam int SCALE_W    = 5;
	localparam int WIDTH_W    = 11;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;
	localparam int PAD_W      = 2;

	// Item kinds.
	localparam logic KIND_PIXEL  = 1'b0;
	localparam logic KIND_REPLAY = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_INPUT_WIDTH  = 1'b1;

	typedef logic [PIX_W-1:0] pix_t;

	// Decisions taken when an item is accepted, carried to the emitter.
	typedef struct packed {
		logic             err;
		logic             replay;
		logic             last_col;
		logic [PAD_W-1:0] pad;
	} item_t;

endpackage

FILE: src/ipu_line_store.sv
// Line store memory: one write port and one registered read port.
module ipu_line_store #(
	parameter int MAX_WIDTH = 1024,
	parameter int AW = 10
) (
	input  logic           clk,
	input  logic           wr_en,
	input  logic [AW-1:0]  wr_addr,
	input  ipu_pkg::pix_t  wr_data,
	input  logic           rd_en,
	input  logic [AW-1:0]  rd_addr,
	output ipu_pkg::pix_t  rd_data
);
	import ipu_pkg::*;

	pix_t store_mem [MAX_WIDTH];
	pix_t rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[wr_addr] <= wr_data;
		end
	end

	// Read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= store_mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: src/ipu_seq.sv
// Row sequencer: configuration registers, column counters and item classification.
module ipu_seq #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_FACTOR = 16,
	parameter int AW = 10,
	parameter int FW = 5
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ipu_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ipu_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              accept,
	input  logic                              kind,
	output ipu_pkg::item_t                    item,
	output logic [FW-1:0]                     factor,
	output logic                              wr_en,
	output logic                              rd_en,
	output logic [AW-1:0]                     addr
);
	import ipu_pkg::*;

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int RW = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;

	logic [SCALE_W-1:0] scale_q;
	logic [WIDTH_W-1:0] width_q;
	logic [AW-1:0]      fill_col_q;
	logic [AW-1:0]      replay_col_q;
	logic [RW-1:0]      rows_left_q;

	logic [FW-1:0]      factor_eff;
	logic [WW-1:0]      width_eff;
	logic [AW-1:0]      col;
	logic               last_col;
	logic               err;
	logic [1:0]         row_bytes_lo;

	// Clamp the configured factor and width to their usable ranges.
	always_comb begin
		if (scale_q == '0) begin
			factor_eff = FW'(1);
		end else if (32'(scale_q) > MAX_FACTOR) begin
			factor_eff = FW'(MAX_FACTOR);
		end else begin
			factor_eff = FW'(scale_q);
		end
		if (width_q == '0) begin
			width_eff = WW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			width_eff = WW'(MAX_WIDTH);
		end else begin
			width_eff = WW'(width_q);
		end
	end

	// Row padding depends only on the low two bits of width and factor.
	assign row_bytes_lo = 2'(4'(2'(width_eff)) * 4'(2'(factor_eff)) * 4'd3);

	// A replay needs pending repeat rows; a new pixel needs none.
	assign err      = (kind == KIND_PIXEL) != (rows_left_q == '0);
	assign col      = (kind == KIND_PIXEL) ? fill_col_q : replay_col_q;
	assign last_col = ((WW + 1)'(col) + (WW + 1)'(1)) >= (WW + 1)'(width_eff);

	assign item.err      = err;
	assign item.replay   = (kind == KIND_REPLAY);
	assign item.last_col = last_col;
	assign item.pad      = 2'(2'd0 - row_bytes_lo);
	assign factor        = factor_eff;
	assign wr_en         = accept && !err && (kind == KIND_PIXEL);
	assign rd_en         = accept && !err && (kind == KIND_REPLAY);
	assign addr          = col;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_W'(1);
			width_q <= WIDTH_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SCALE_FACTOR: scale_q <= cfg_data[SCALE_W-1:0];
				CFG_INPUT_WIDTH:  width_q <= cfg_data[WIDTH_W-1:0];
				default: ;
			endcase
		end
	end

	// Column and repeat-row counters advance on each accepted, in-sequence item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_col_q   <= '0;
			replay_col_q <= '0;
			rows_left_q  <= '0;
		end else if (accept && !err) begin
			if (kind == KIND_PIXEL) begin
				if (last_col) begin
					fill_col_q   <= '0;
					replay_col_q <= '0;
					rows_left_q  <= RW'(factor_eff - FW'(1));
				end else begin
					fill_col_q <= col + AW'(1);
				end
			end else begin
				if (last_col) begin
					replay_col_q <= '0;
					rows_left_q  <= rows_left_q - RW'(1);
				end else begin
					replay_col_q <= col + AW'(1);
				end
			end
		end
	end

endmodule

FILE: src/ipu_emit.sv
// Run emitter: holds one item and sends its copies through the output register.
module ipu_emit #(
	parameter int FW = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  ipu_pkg::item_t                item,
	input  logic [FW-1:0]                 factor,
	input  ipu_pkg::pix_t                 pix_in,
	input  ipu_pkg::pix_t                 rd_data,
	output logic                          take_ready,
	output logic                          out_valid,
	input  logic                          out_ready,
	output ipu_pkg::pix_t                 out_pix,
	output logic                          out_row_end,
	output logic [ipu_pkg::PAD_W-1:0]     out_pad,
	output logic                          out_run_last,
	output logic                          out_err
);
	import ipu_pkg::*;

	logic              valid_s1;
	item_t             item_s1;
	pix_t              pix_s1;
	logic [FW-1:0]     left_s1;

	logic              out_valid_q;
	pix_t              pix_q;
	logic              row_end_q;
	logic [PAD_W-1:0]  pad_q;
	logic              run_last_q;
	logic              err_q;

	logic              final_copy;
	logic              emit;
	pix_t              pix_sel;

	assign final_copy = (left_s1 == '0);
	assign emit       = valid_s1 && (!out_valid_q || out_ready);
	assign take_ready = !valid_s1 || (emit && final_copy);

	// Replays take their pixel from the line store read port.
	always_comb begin
		if (item_s1.err) begin
			pix_sel = '0;
		end else if (item_s1.replay) begin
			pix_sel = rd_data;
		end else begin
			pix_sel = pix_s1;
		end
	end

	// Control state of the item stage and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_s1 <= 1'b1;
			end else if (emit && final_copy) begin
				valid_s1 <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item payload and copy counter.
	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item;
			pix_s1  <= pix_in;
			left_s1 <= item.err ? '0 : FW'(factor - FW'(1));
		end else if (emit) begin
			left_s1 <= left_s1 - FW'(1);
		end
	end

	// Output payload for each copy.
	always_ff @(posedge clk) begin
		if (emit) begin
			pix_q      <= pix_sel;
			row_end_q  <= final_copy && item_s1.last_col && !item_s1.err;
			pad_q      <= (final_copy && item_s1.last_col && !item_s1.err) ? item_s1.pad : '0;
			run_last_q <= final_copy;
			err_q      <= item_s1.err;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_pix      = pix_q;
	assign out_row_end  = row_end_q;
	assign out_pad      = pad_q;
	assign out_run_last = run_last_q;
	assign out_err      = err_q;

endmodule

FILE: src/integer_pixel_upscaler.sv
// Top level of the nearest-neighbour integer pixel upscaler.
//
//   Channel   Handshake                   Payload
//   cfg       cfg_valid / cfg_ready       cfg_index, cfg_data
//   input     in_valid / in_ready         kind, in_blue, in_green, in_red
//   output    out_valid / out_ready       out_blue, out_green, out_red, row_end,
//                                         pad_bytes, run_last, seq_error
//
// An item gives factor output pixels (one if out of sequence), one per cycle
// unless the output stalls; with factor 1 an item can be transferred every
// cycle. The input transfer loads the emitter's item stage; each copy leaves
// through the output register. Replays use the store's registered read port.
// Reset clears counters and handshake state; the store is not cleared. A
// stalled output holds the emitter, which then holds in_ready low.
module integer_pixel_upscaler #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_FACTOR = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ipu_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ipu_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              kind,
	input  logic [ipu_pkg::CHAN_W-1:0]        in_blue,
	input  logic [ipu_pkg::CHAN_W-1:0]        in_green,
	input  logic [ipu_pkg::CHAN_W-1:0]        in_red,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ipu_pkg::CHAN_W-1:0]        out_blue,
	output logic [ipu_pkg::CHAN_W-1:0]        out_green,
	output logic [ipu_pkg::CHAN_W-1:0]        out_red,
	output logic                              row_end,
	output logic [ipu_pkg::PAD_W-1:0]         pad_bytes,
	output logic                              run_last,
	output logic                              seq_error
);
	import ipu_pkg::*;

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int FW = $clog2(MAX_FACTOR + 1);

	logic           accept;
	item_t          item;
	logic [FW-1:0]  factor;
	logic           wr_en;
	logic           rd_en;
	logic [AW-1:0]  addr;
	pix_t           pix_in;
	pix_t           rd_data;
	pix_t           out_pix;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;
	assign pix_in    = {in_red, in_green, in_blue};

	ipu_seq #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_FACTOR(MAX_FACTOR),
		.AW        (AW),
		.FW        (FW)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.accept   (accept),
		.kind     (kind),
		.item     (item),
		.factor   (factor),
		.wr_en    (wr_en),
		.rd_en    (rd_en),
		.addr     (addr)
	);

	ipu_line_store #(
		.MAX_WIDTH(MAX_WIDTH),
		.AW       (AW)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(addr),
		.wr_data(pix_in),
		.rd_en  (rd_en),
		.rd_addr(addr),
		.rd_data(rd_data)
	);

	ipu_emit #(
		.FW(FW)
	) u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (accept),
		.item        (item),
		.factor      (factor),
		.pix_in      (pix_in),
		.rd_data     (rd_data),
		.take_ready  (in_ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_pix     (out_pix),
		.out_row_end (row_end),
		.out_pad     (pad_bytes),
		.out_run_last(run_last),
		.out_err     (seq_error)
	);

	assign out_blue  = out_pix[CHAN_W-1:0];
	assign out_green = out_pix[2*CHAN_W-1:CHAN_W];
	assign out_red   = out_pix[3*CHAN_W-1:2*CHAN_W];

endmodule

FILE: bench/integer_pixel_upscaler_tb.sv
// Self-checking testbench for the integer pixel upscaler, with a built-in raster model.
`timescale 1ns / 1ps

module integer_pixel_upscaler_tb;
	import ipu_pkg::*;

	localparam int unsigned MAX_WIDTH  = 1024;
	localparam int unsigned MAX_FACTOR = 16;
	localparam int unsigned SETTLE_CYCLES = 8;

	// One input transfer as it waits in the send queue.
	typedef struct packed {
		logic              kind;
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
	} upscale_item_t;

	// One output pixel, in the order of the output ports.
	typedef struct packed {
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
		logic              row_end;
		logic [PAD_W-1:0]  pad;
		logic              run_last;
		logic              seq_error;
	} pixel_result_t;

	// Row counters and register copies of the raster walk.
	typedef struct {
		int unsigned          fill_col;
		int unsigned          replay_col;
		int unsigned          rows_left;
		logic [SCALE_W-1:0]   factor;
		logic [WIDTH_W-1:0]   width;
	} raster_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_SCALE_FACTOR;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic kind = KIND_PIXEL;
	logic [CHAN_W-1:0] in_blue = '0;
	logic [CHAN_W-1:0] in_green = '0;
	logic [CHAN_W-1:0] in_red = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [CHAN_W-1:0] out_blue;
	logic [CHAN_W-1:0] out_green;
	logic [CHAN_W-1:0] out_red;
	logic row_end;
	logic [PAD_W-1:0] pad_bytes;
	logic run_last;
	logic seq_error;

	upscale_item_t pending_items[$];
	pixel_result_t expected_pixels[$];
	upscale_item_t next_item;
	pixel_result_t got_pixel;
	pixel_result_t want_pixel;

	// The model seen by the checker, and the copy the stimulus plans with.
	raster_t scaler = '{fill_col: 0, replay_col: 0, rows_left: 0, factor: 1, width: 1};
	raster_t plan = '{fill_col: 0, replay_col: 0, rows_left: 0, factor: 1, width: 1};
	pix_t line_copy [MAX_WIDTH];
	int unsigned stored_span = 0;

	int unsigned mismatches = 0;
	int unsigned send_gap = 0;
	int unsigned stall_left = 0;
	bit idle_bursts = 1'b1;

	integer_pixel_upscaler uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.in_blue(in_blue),
		.in_green(in_green),
		.in_red(in_red),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_blue(out_blue),
		.out_green(out_green),
		.out_red(out_red),
		.row_end(row_end),
		.pad_bytes(pad_bytes),
		.run_last(run_last),
		.seq_error(seq_error)
	);

	always #6 clk = ~clk;

	function automatic int unsigned clamp_factor(input logic [SCALE_W-1:0] f);
		if (f == 0) return 1;
		if (f > MAX_FACTOR) return MAX_FACTOR;
		return 32'(f);
	endfunction

	function automatic int unsigned clamp_width(input logic [WIDTH_W-1:0] w);
		if (w == 0) return 1;
		if (w > MAX_WIDTH) return MAX_WIDTH;
		return 32'(w);
	endfunction

	// Moves the raster walk on by one item. Returns 0 for an item out of
	// sequence, which leaves the counters untouched.
	function automatic bit step_raster(inout raster_t r, input logic k,
			output int unsigned col, output bit last_col);
		int unsigned w;
		int unsigned f;
		w = clamp_width(r.width);
		f = clamp_factor(r.factor);
		col = 0;
		last_col = 1'b0;
		if ((k == KIND_PIXEL) != (r.rows_left == 0))
			return 1'b0;
		if (k == KIND_PIXEL) begin
			col = (r.fill_col >= MAX_WIDTH) ? 0 : r.fill_col;
			last_col = (col + 1 >= w);
			if (last_col) begin
				r.fill_col = 0;
				r.replay_col = 0;
				r.rows_left = f - 1;
			end else begin
				r.fill_col = col + 1;
			end
		end else begin
			col = (r.replay_col >= MAX_WIDTH) ? 0 : r.replay_col;
			last_col = (col + 1 >= w);
			if (last_col) begin
				r.replay_col = 0;
				r.rows_left = r.rows_left - 1;
			end else begin
				r.replay_col = col + 1;
			end
		end
		return 1'b1;
	endfunction

	// Works out the output pixels of one accepted item and queues them.
	function automatic void predict_pixels(input logic k, input pix_t pix_in);
		int unsigned col;
		int unsigned f;
		int unsigned w;
		int unsigned pad;
		bit last_col;
		pix_t pix;
		pixel_result_t res;
		f = clamp_factor(scaler.factor);
		w = clamp_width(scaler.width);
		pad = (4 - ((3 * w * f) & 3)) & 3;
		res = '0;
		if (!step_raster(scaler, k, col, last_col)) begin
			res.run_last = 1'b1;
			res.seq_error = 1'b1;
			expected_pixels.push_back(res);
			return;
		end
		if (k == KIND_PIXEL) begin
			line_copy[col] = pix_in;
			pix = pix_in;
		end else begin
			pix = line_copy[col];
		end
		for (int unsigned c = 0; c < f; c++) begin
			res.blue = pix[7:0];
			res.green = pix[15:8];
			res.red = pix[23:16];
			res.run_last = (c + 1 == f);
			res.row_end = res.run_last && last_col;
			res.pad = res.row_end ? pad[PAD_W-1:0] : '0;
			res.seq_error = 1'b0;
			expected_pixels.push_back(res);
		end
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_factor();
		logic [CFG_DATA_W-1:0] odd [4] = '{0, 16, 17, 31};
		if ($urandom_range(0, 9) == 0) return odd[$urandom_range(0, 3)];
		return CFG_DATA_W'($urandom_range(1, 4));
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_width();
		logic [CFG_DATA_W-1:0] odd [5] = '{0, 1023, 1024, 1025, 2047};
		if ($urandom_range(0, 9) == 0) return odd[$urandom_range(0, 4)];
		return CFG_DATA_W'($urandom_range(1, 6));
	endfunction

	// Queues one item and follows it in the planning copy of the raster.
	task automatic add_item(input logic k, input pix_t pix);
		int unsigned col;
		bit last_col;
		pending_items.push_back({k, pix[7:0], pix[15:8], pix[23:16]});
		if (step_raster(plan, k, col, last_col) && k == KIND_PIXEL && col + 1 > stored_span)
			stored_span = col + 1;
	endtask

	// Mostly the kind the raster expects next, with the odd one out of sequence.
	task automatic add_random_items(input int unsigned n);
		logic k;
		repeat (n) begin
			k = (plan.rows_left == 0) ? KIND_PIXEL : KIND_REPLAY;
			if ($urandom_range(0, 9) == 0)
				k = ~k;
			add_item(k, pix_t'($urandom));
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// While repeat rows are pending the width never grows past the stored
	// pixels, so no replay reads an entry that was never filled.
	task automatic set_config(input logic [CFG_DATA_W-1:0] f, input logic [CFG_DATA_W-1:0] w);
		if (plan.rows_left != 0 && clamp_width(w) > stored_span)
			w = CFG_DATA_W'(stored_span);
		write_reg(CFG_SCALE_FACTOR, f);
		write_reg(CFG_INPUT_WIDTH, w);
		plan.factor = f[SCALE_W-1:0];
		plan.width = w;
	endtask

	// Holds the sender until every queued item has been sent and answered.
	task automatic drain();
		@(negedge clk);
		while (pending_items.size() != 0 || in_valid || expected_pixels.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Input driver: takes items from the send queue, with gaps in bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else if (!in_valid || in_ready) begin
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				next_item = pending_items.pop_front();
				in_valid <= 1'b1;
				kind <= next_item.kind;
				in_blue <= next_item.blue;
				in_green <= next_item.green;
				in_red <= next_item.red;
				if (idle_bursts && $urandom_range(0, 4) == 0)
					send_gap <= $urandom_range(1, 3);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output stalls come in bursts as well.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (idle_bursts && $urandom_range(0, 4) == 0)
				stall_left <= $urandom_range(1, 3);
		end
	end

	// Monitor: follows register writes and input transfers, checks each output transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_SCALE_FACTOR)
					scaler.factor = cfg_data[SCALE_W-1:0];
				else
					scaler.width = cfg_data[WIDTH_W-1:0];
			end
			if (in_valid && in_ready)
				predict_pixels(kind, {in_red, in_green, in_blue});
			if (out_valid && out_ready) begin
				got_pixel = {out_blue, out_green, out_red, row_end, pad_bytes, run_last,
					seq_error};
				if (expected_pixels.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected output pixel %h", $realtime, got_pixel);
				end else begin
					want_pixel = expected_pixels.pop_front();
					if (got_pixel !== want_pixel) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: got b=%h g=%h r=%h end=%b pad=%0d last=%b err=%b,",
								$realtime, got_pixel.blue, got_pixel.green, got_pixel.red,
								got_pixel.row_end, got_pixel.pad, got_pixel.run_last,
								got_pixel.seq_error,
								" expected b=%h g=%h r=%h end=%b pad=%0d last=%b err=%b",
								want_pixel.blue, want_pixel.green,
								want_pixel.red, want_pixel.row_end, want_pixel.pad,
								want_pixel.run_last, want_pixel.seq_error);
					end
				end
			end
		end
	end

	// Stimulus sequence.
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Zero in both registers acts as one: every replay is out of sequence.
		set_config(0, 0);
		add_item(KIND_PIXEL, 24'hFFFFFF);
		add_item(KIND_REPLAY, 24'h123456);
		add_item(KIND_PIXEL, 24'h000000);
		drain();

		// Factor above the maximum, a one-pixel row, stray items on both sides.
		set_config(31, 1);
		add_item(KIND_PIXEL, 24'h0FC3A5);
		repeat (7) add_item(KIND_REPLAY, 24'h000000);
		add_item(KIND_PIXEL, 24'hFFFFFF);
		repeat (8) add_item(KIND_REPLAY, 24'hFFFFFF);
		add_item(KIND_REPLAY, 24'h5A5A5A);
		drain();

		// Width above the maximum, then a narrower row part-way through the fill.
		set_config(2, 2047);
		repeat (3) add_item(KIND_PIXEL, pix_t'($urandom));
		drain();
		set_config(3, 2);
		add_item(KIND_PIXEL, pix_t'($urandom));
		drain();

		// Random rasters, changing the settings between phases; the last one runs flat out.
		for (int p = 0; p < 8; p++) begin
			if (p == 7)
				idle_bursts = 1'b0;
			set_config(pick_factor(), pick_width());
			add_random_items(32);
			drain();
		end

		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

endmodule
